/* src/fba_pkg.sv */
// Shared types and constants for the fit block allocator.
package fba_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic REG_FIT_MODE      = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;

    localparam int CFG_DATA_W = 7;
    localparam logic [6:0] BLOCKS_RESET = 7'd64;

    typedef struct packed {
        logic        command;
        logic [5:0]  block_index;
        logic [15:0] size;
    } in_item_t;

    typedef struct packed {
        logic        granted;
        logic [5:0]  chosen_block;
        logic [15:0] space_left;
    } out_item_t;

    typedef struct packed {
        logic take_item;
        logic load_write;
        logic scan_start;
        logic scan_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic scan_empty;
    } ctrl_status_t;

endpackage

/* src/fba_controller.sv */
// Sequencing state machine for load and allocate transactions.
module fba_controller
    import fba_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         item_command,
    output logic         m_valid,
    input  logic         m_ready,
    output ctrl_cmd_t    cmd,
    input  ctrl_status_t status
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       accept;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd            = '0;
        cmd.take_item  = accept;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (item_command == CMD_LOAD) begin
                        cmd.load_write = 1'b1;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next = status.scan_empty ? ST_WRITE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                // The result register must be free before the write-back commits.
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* src/fba_datapath.sv */
// Free-space memory, scan pointer, fit comparison and result register.
module fba_datapath
    import fba_pkg::*;
#(
    parameter int NUM_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_item_t              s_item,
    input  ctrl_cmd_t             cmd,
    output ctrl_status_t          status,
    output out_item_t             m_item
);

    localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int AW_MAX = (IDX_W > 6) ? IDX_W : 6;
    localparam int SW_MAX = (SIZE_BITS > 16) ? SIZE_BITS : 16;
    localparam int CNT_W  = 9;
    localparam logic [CNT_W-1:0] NUM_BLOCKS_C = CNT_W'(NUM_BLOCKS);

    logic [SIZE_BITS-1:0] free_mem [NUM_BLOCKS];

    logic [1:0]           mode_reg;
    logic [6:0]           blocks_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic [IDX_W-1:0]     ptr_reg;
    logic [SIZE_BITS-1:0] rdata_reg;
    logic                 cmp_valid_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [SIZE_BITS-1:0] best_reg;
    out_item_t            out_reg;

    logic [CNT_W-1:0]     count;
    logic [SW_MAX-1:0]    size_wide;
    logic [SIZE_BITS-1:0] size_in;
    logic [AW_MAX-1:0]    load_addr_wide;
    logic                 load_in_range;
    logic                 fits;
    logic                 better;
    logic                 take;
    logic [SIZE_BITS-1:0] remain;
    logic [SW_MAX-1:0]    remain_wide;
    logic [AW_MAX-1:0]    pick_wide;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;

    assign count = ({2'b00, blocks_reg} > NUM_BLOCKS_C) ? NUM_BLOCKS_C : {2'b00, blocks_reg};
    assign status.scan_empty = (count == '0);
    assign status.scan_last  = ((CNT_W'(ptr_reg) + CNT_W'(1)) == count);

    assign size_wide      = SW_MAX'(s_item.size);
    assign size_in        = size_wide[SIZE_BITS-1:0];
    assign load_addr_wide = AW_MAX'(s_item.block_index);
    assign load_in_range  = (CNT_W'(s_item.block_index) < NUM_BLOCKS_C);

    assign fits = (rdata_reg >= req_reg);
    always_comb begin
        case (mode_reg)
            MODE_BEST:  better = (rdata_reg < best_reg);
            MODE_WORST: better = (rdata_reg > best_reg);
            default:    better = 1'b0;
        endcase
    end
    assign take = cmp_valid_reg && fits && (!found_reg || better);

    assign remain      = best_reg - req_reg;
    assign remain_wide = SW_MAX'(remain);
    assign pick_wide   = AW_MAX'(pick_reg);

    // One write port serves both loads and the allocation write-back.
    assign wr_en   = (cmd.load_write && load_in_range) || (cmd.commit && found_reg);
    assign wr_addr = cmd.commit ? pick_reg : load_addr_wide[IDX_W-1:0];
    assign wr_data = cmd.commit ? remain : size_in;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            free_mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_step) begin
            rdata_reg <= free_mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_FIRST;
            blocks_reg    <= BLOCKS_RESET;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            ptr_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FIT_MODE:      mode_reg   <= cfg_wdata[1:0];
                    REG_BLOCKS_IN_USE: blocks_reg <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            cmp_valid_reg <= cmd.scan_step;
            if (cmd.scan_start) begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end else begin
                if (cmd.scan_step) begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                if (take) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            req_reg <= size_in;
        end
        if (cmd.scan_step) begin
            cmp_idx_reg <= ptr_reg;
        end
        if (take) begin
            pick_reg <= cmp_idx_reg;
            best_reg <= rdata_reg;
        end
        if (cmd.commit) begin
            out_reg.granted      <= found_reg;
            out_reg.chosen_block <= found_reg ? pick_wide[5:0] : 6'd0;
            out_reg.space_left   <= found_reg ? remain_wide[15:0] : 16'd0;
        end
    end

    assign m_item = out_reg;

endmodule

/* src/fit_block_allocator_unit.sv */
// A load is written to the free-space memory as it is accepted; an allocate scans the blocks
// in use (blocks_in_use capped at NUM_BLOCKS; no scan when no block is in use), drains, and
// commits and raises m_valid once the output register is free. A new item is taken only in
// idle, after the write-back; the single read port of the memory scans one block per cycle.
// A new transaction is accepted while a finished result still waits in the output register.
// Reset (aresetn, synchronous, active low) sets first fit, 64 blocks in use and empties
// the pipeline; the free-space memory is not cleared and must be loaded before use.
module fit_block_allocator_unit
    import fba_pkg::*;
#(
    parameter int NUM_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    fba_controller u_controller (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .item_command (s_item.command),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .cmd          (cmd),
        .status       (status)
    );

    fba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_item    (s_item),
        .cmd       (cmd),
        .status    (status),
        .m_item    (m_item)
    );

endmodule
